### rtl/dss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg - shared definitions for the delimiter string splitter
// Sizes of the string position counters, delimiter window and result beat.
// ----------------------------------------------------------------------------
package dss_pkg;

    // longest string that is counted and matched
    localparam int MAX_STRING_LENGTH   = 65536;
    // widest delimiter supported
    localparam int MAX_DELIMITER_BYTES = 8;

    // position counter holds 0 .. MAX_STRING_LENGTH
    localparam int POS_W    = $clog2(MAX_STRING_LENGTH + 1);
    localparam int WIN_W    = 8 * MAX_DELIMITER_BYTES;
    localparam int DLEN_W   = 4;
    localparam int OFFSET_W = 16;
    localparam int LENGTH_W = 17;
    localparam int TOTAL_W  = 17;

    // result tdata: offset, length, total, padded to whole bytes
    localparam int RES_W   = OFFSET_W + LENGTH_W + TOTAL_W;
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_DELIM_BYTES  = 1'b0,
        CFG_DELIM_LENGTH = 1'b1
    } cfg_index_t;

    // one result beat
    typedef struct packed {
        logic                has_fragment;
        logic [OFFSET_W-1:0] frag_offset;
        logic [LENGTH_W-1:0] frag_length;
        logic                end_of_string;
        logic [TOTAL_W-1:0]  fragment_total;
        logic                length_overflow;
    } frag_result_t;

endpackage

### rtl/delimiter_string_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimiter_string_splitter - split a byte stream on a multibyte delimiter
// Reports each nonempty fragment as offset and length, closes each string.
// ----------------------------------------------------------------------------
// Usage
//   s_* carries one string byte per beat, s_tlast on the final byte.
//   m_* carries a result beat: tdata holds offset, length and fragment total,
//   tuser holds the fragment and overflow flags, tlast marks the closing beat.
//   A beat comes out when a delimiter ends a nonempty fragment, and always on
//   the last byte of a string (with the tail fragment if there is one).
//   cfg_we/cfg_index/cfg_data write the delimiter bytes (index 0) and the
//   delimiter length (index 1); write only while the block is idle.
// Timing
//   the result beat is registered, valid in the cycle after its byte is taken;
//   one byte is taken every cycle that s_tready is high, set by the single
//   window compare and position update between the state registers and the
//   result register. s_tready drops only while a beat is held with m_tready low.
// Reset
//   clears all string state, delimiter bytes to zero, delimiter length to 1.
//   After each closing beat the string state returns to zero.
// ----------------------------------------------------------------------------
module delimiter_string_splitter
    import dss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [WIN_W-1:0]   cfg_data,
    // input bytes
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte[7:0]
    input  logic               s_tlast,   // last_byte
    // result beats
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // frag_offset[15:0], frag_length[32:16],
                                          // fragment_total[49:33], zero pad
    output logic [1:0]         m_tuser,   // has_fragment[0], length_overflow[1]
    output logic               m_tlast    // end_of_string
);

    // configuration registers
    logic [WIN_W-1:0]  delim_bytes_reg;
    logic [DLEN_W-1:0] delim_length_reg;

    // string state
    logic [WIN_W-1:0]   recent_reg, recent_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic [TOTAL_W-1:0] count_reg, count_next;
    logic               ovf_reg, ovf_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    frag_result_t       res_reg, res_next;

    logic                      accept;
    logic                      emit;
    logic [DLEN_W-1:0]         dlen;
    logic [WIN_W-1:0]          window;
    logic [MAX_DELIMITER_BYTES-1:0] len_match;
    logic                      full;
    logic [POS_W-1:0]          pos_inc;
    logic [POS_W-1:0]          span;
    logic [POS_W-1:0]          match_start;
    logic                      matched;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_bytes_reg  <= '0;
            delim_length_reg <= DLEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DELIM_BYTES:  delim_bytes_reg  <= cfg_data;
                CFG_DELIM_LENGTH: delim_length_reg <= cfg_data[DLEN_W-1:0];
                default:          delim_bytes_reg  <= delim_bytes_reg;
            endcase
        end
    end

    // effective delimiter length, clamped to 1 .. max
    always_comb
    begin
        if (delim_length_reg == '0)
            dlen = DLEN_W'(1);
        else if (delim_length_reg > DLEN_W'(MAX_DELIMITER_BYTES))
            dlen = DLEN_W'(MAX_DELIMITER_BYTES);
        else
            dlen = delim_length_reg;
    end

    // window with the new byte, compared for every delimiter length at once
    assign window = {recent_reg[WIN_W-9:0], s_tdata};

    always_comb
    begin
        for (int l = 1; l <= MAX_DELIMITER_BYTES; l++)
        begin
            len_match[l-1] = 1'b1;
            for (int j = 0; j < l; j++)
            begin
                if (window[8*(l-1-j) +: 8] != delim_bytes_reg[8*j +: 8])
                    len_match[l-1] = 1'b0;
            end
        end
    end

    // position arithmetic
    assign full        = (pos_reg >= POS_W'(MAX_STRING_LENGTH));
    assign pos_inc     = pos_reg + POS_W'(1);
    assign span        = pos_inc - start_reg;
    assign match_start = pos_inc - POS_W'(dlen);
    assign matched     = !full && (span >= POS_W'(dlen))
                         && len_match[dlen[$clog2(MAX_DELIMITER_BYTES+1)-2:0] - 1'b1];

    // next string state and result for the current byte
    always_comb
    begin
        recent_next = recent_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        res_next    = '0;

        if (full)
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            recent_next = window;
            pos_next    = pos_inc;
        end

        // delimiter completed: report the fragment before it if nonempty
        if (matched)
        begin
            if (match_start > start_reg)
            begin
                res_next.has_fragment = 1'b1;
                res_next.frag_offset  = start_reg[OFFSET_W-1:0];
                res_next.frag_length  = LENGTH_W'(match_start - start_reg);
                count_next            = count_reg + TOTAL_W'(1);
            end
            start_next = pos_inc;
        end

        // tail fragment on the last byte
        if (!res_next.has_fragment && s_tlast && (pos_next > start_next))
        begin
            res_next.has_fragment = 1'b1;
            res_next.frag_offset  = start_next[OFFSET_W-1:0];
            res_next.frag_length  = LENGTH_W'(pos_next - start_next);
            count_next            = count_reg + TOTAL_W'(1);
            start_next            = pos_next;
        end

        res_next.end_of_string   = s_tlast;
        res_next.fragment_total  = count_next;
        res_next.length_overflow = ovf_next;

        // closing beat returns the string state to zero
        if (s_tlast)
        begin
            recent_next = '0;
            pos_next    = '0;
            start_next  = '0;
            count_next  = '0;
            ovf_next    = 1'b0;
        end
    end

    assign emit = res_next.has_fragment || s_tlast;

    // string state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= '0;
            pos_reg    <= '0;
            start_reg  <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (accept)
        begin
            recent_reg <= recent_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
        end
    end

    // result register valid
    always_comb
    begin
        if (accept && emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result payload, loaded with each emitted beat
    always_ff @(posedge clk)
    begin
        if (accept && emit)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - RES_W){1'b0}}, res_reg.fragment_total,
                       res_reg.frag_length, res_reg.frag_offset};
    assign m_tuser  = {res_reg.length_overflow, res_reg.has_fragment};
    assign m_tlast  = res_reg.end_of_string;

`ifndef SYNTHESIS
    // a reported fragment is never empty
    a_frag_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[OFFSET_W +: LENGTH_W] != '0))
        else $error("fragment beat with zero length");

    // every beat carries a fragment or closes a string
    a_beat_meaningful: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] || m_tlast))
        else $error("result beat with neither fragment nor end of string");

    // string state is cleared after the last byte
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (pos_reg == '0 && count_reg == '0 && !ovf_reg))
        else $error("string state not cleared after last byte");

    // position saturates and fragment start never passes it
    a_pos_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg <= POS_W'(MAX_STRING_LENGTH)) && (start_reg <= pos_reg))
        else $error("position counter out of range");
`endif

endmodule
